// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the LCD nibble sequencer.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("assertion failed");

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/clns_pkg.sv
// Types and constants of the character LCD nibble sequencer.
// Used by every module of the block; depends on nothing.
package clns_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CMD    = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_CURSOR = 3'd4,
    CMD_GLYPH  = 3'd5
  } cmd_e;

  localparam logic [7:0]  LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0]  LCD_DISP_ON    = 8'h0C;
  localparam logic [7:0]  LCD_CLR_DISP   = 8'h01;
  localparam logic [7:0]  LCD_DDRAM_L0   = 8'h80;
  localparam logic [7:0]  LCD_DDRAM_L1   = 8'hC0;
  localparam logic [7:0]  LCD_CGRAM      = 8'h40;
  localparam logic [18:0] WAIT_POWER_UP  = 19'd500000;
  localparam logic [18:0] WAIT_FIRST_NIB = 19'd50000;
  localparam logic [18:0] WAIT_NIB       = 19'd10000;
  localparam logic [18:0] WAIT_CLEAR     = 19'd40000;
  localparam logic [2:0]  PRO_LAST       = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
    logic [2:0] location;
    logic [2:0] glyph_row;
  } req_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [18:0] wait_after;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } lcd_byte_t;

  // decoded request: optional init prologue, then one to three bytes
  typedef struct packed {
    logic                 init;
    logic [1:0]           last_idx;
    logic                 long_wait;
    lcd_byte_t [2:0]      bytes;
  } job_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PRO  = 3'b010,
    PH_BYTE = 3'b100
  } phase_e;

  function automatic logic [3:0] pro_nibble(input logic [2:0] step);
    logic [3:0] nib;
    unique case (step)
      3'd1, 3'd2, 3'd3: nib = 4'h3;
      3'd4:             nib = 4'h2;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [18:0] pro_wait(input logic [2:0] step);
    logic [18:0] w;
    unique case (step)
      3'd0:             w = WAIT_POWER_UP;
      3'd1:             w = WAIT_FIRST_NIB;
      3'd2, 3'd3, 3'd4: w = WAIT_NIB;
      default:          w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/clns_front.sv
// Front end: classifies one request into a job descriptor.
// Depends on clns_pkg.
module clns_front (
  input  clns_pkg::req_t req_i,
  output logic           job_valid_o,
  output clns_pkg::job_t job_o
);
  import clns_pkg::*;

  logic [7:0] cursor_addr;

  assign cursor_addr = (req_i.row ? LCD_DDRAM_L1 : LCD_DDRAM_L0) + {2'b00, req_i.col};

  always_comb begin
    job_valid_o = 1'b1;
    job_o       = '0;
    unique case (cmd_e'(req_i.cmd))
      CMD_INIT: begin
        job_o.init      = 1'b1;
        job_o.last_idx  = 2'd2;
        job_o.long_wait = 1'b1;
        job_o.bytes[0]  = '{rs: 1'b0, data: LCD_FUNC_SET};
        job_o.bytes[1]  = '{rs: 1'b0, data: LCD_DISP_ON};
        job_o.bytes[2]  = '{rs: 1'b0, data: LCD_CLR_DISP};
      end
      CMD_CMD: begin
        job_o.bytes[0] = '{rs: 1'b0, data: req_i.value};
      end
      CMD_DATA: begin
        job_o.bytes[0] = '{rs: 1'b1, data: req_i.value};
      end
      CMD_CLEAR: begin
        job_o.long_wait = 1'b1;
        job_o.bytes[0]  = '{rs: 1'b0, data: LCD_CLR_DISP};
      end
      CMD_CURSOR: begin
        job_o.bytes[0] = '{rs: 1'b0, data: cursor_addr};
      end
      CMD_GLYPH: begin
        if (req_i.glyph_row == 3'd0) begin
          job_o.last_idx = 2'd1;
          job_o.bytes[0] = '{rs: 1'b0, data: LCD_CGRAM | {2'b00, req_i.location, 3'b000}};
          job_o.bytes[1] = '{rs: 1'b1, data: req_i.value};
        end else if (req_i.glyph_row == 3'd7) begin
          job_o.last_idx = 2'd1;
          job_o.bytes[0] = '{rs: 1'b1, data: req_i.value};
          job_o.bytes[1] = '{rs: 1'b0, data: LCD_DDRAM_L0};
        end else begin
          job_o.bytes[0] = '{rs: 1'b1, data: req_i.value};
        end
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/clns_queue.sv
// Two-entry job queue between the front end and the transfer sequencer.
// Depends on clns_pkg.
module clns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output clns_pkg::job_t job_o
);
  import clns_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/clns_back.sv
// Back end: walks a job and emits one nibble transfer per cycle.
// Depends on clns_pkg.
module clns_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  clns_pkg::job_t job_i,
  output logic           pop_o,
  output logic           valid_o,
  output clns_pkg::res_t res_o
);
  import clns_pkg::*;

  phase_e     phase_q, phase_d;
  job_t       job_q, job_d;
  logic [2:0] step_q, step_d;
  logic [1:0] bidx_q, bidx_d;
  logic       half_q, half_d;
  logic       valid_q, valid_d;
  res_t       res_q, res_d;
  lcd_byte_t  cur_byte;
  logic       last_byte, done;

  assign cur_byte  = job_q.bytes[bidx_q];
  assign last_byte = (bidx_q == job_q.last_idx);

  always_comb begin
    res_d   = '0;
    valid_d = 1'b0;
    unique case (phase_q)
      PH_PRO: begin
        valid_d          = 1'b1;
        res_d.nibble     = pro_nibble(step_q);
        res_d.strobe_res = (step_q != 3'd0);
        res_d.wait_after = pro_wait(step_q);
      end
      PH_BYTE: begin
        valid_d          = 1'b1;
        res_d.rs         = cur_byte.rs;
        res_d.nibble     = half_q ? cur_byte.data[3:0] : cur_byte.data[7:4];
        res_d.strobe_res = 1'b1;
        res_d.last       = half_q && last_byte;
        res_d.wait_after = (half_q && last_byte && job_q.long_wait) ? WAIT_CLEAR : '0;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  assign done  = valid_d && res_d.last;
  assign pop_o = job_valid_i && (phase_q == PH_IDLE || done);

  always_comb begin
    phase_d = phase_q;
    job_d   = job_q;
    step_d  = step_q;
    bidx_d  = bidx_q;
    half_d  = half_q;
    if (phase_q == PH_IDLE || done) begin
      step_d = '0;
      bidx_d = '0;
      half_d = 1'b0;
      if (job_valid_i) begin
        job_d   = job_i;
        phase_d = job_i.init ? PH_PRO : PH_BYTE;
      end else begin
        phase_d = PH_IDLE;
      end
    end else if (phase_q == PH_PRO) begin
      if (step_q == PRO_LAST) begin
        phase_d = PH_BYTE;
      end else begin
        step_d = step_q + 3'd1;
      end
    end else begin
      if (half_q) begin
        bidx_d = bidx_q + 2'd1;
        half_d = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      bidx_q  <= '0;
      half_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      bidx_q  <= bidx_d;
      half_q  <= half_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hdl/char_lcd_nibble_sequencer.sv
// Character LCD 4-bit request sequencer, top level.
// Depends on clns_pkg, clns_front, clns_queue, clns_back, assert_macros.svh.
//
// Usage:
//   A request (req_i) is taken at a clock edge with start_i high and busy_o low.
//   Each request expands into nibble transfers on res_o, one per cycle, each
//   marked by valid_o for exactly one cycle; res_o.last flags the final one.
//   A request's first transfer goes through the queue, phase and output registers
//   if the sequencer is free. Byte requests give 2 transfers, glyph rows 2 or 4,
//   init 11. Requests of kinds 6 and 7 are taken and give no transfers.
//   Throughput is set by the sequencer at one transfer per cycle; consecutive
//   requests follow without gaps. A two-deep request queue sits in front of
//   it, and busy_o is high while that queue is full.
//   The receiver cannot stall: every transfer must be taken when shown.
//   cfg_we_i / cfg_wdata_i write the enable half period (reset 8000); it
//   only feeds an internal assertion and does not change any transfer field.
//   Reset empties the queue and idles the sequencer.
module char_lcd_nibble_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  clns_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [19:0]    cfg_wdata_i,
  output logic           valid_o,
  output clns_pkg::res_t res_o
);
  import clns_pkg::*;

  `include "assert_macros.svh"

  logic        half_nonzero;
  logic [19:0] en_half_q;
  logic        fe_valid, q_full, q_valid, q_pop;
  job_t        fe_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_half_q <= 20'd8000;
    end else if (cfg_we_i) begin
      en_half_q <= cfg_wdata_i;
    end
  end

  assign half_nonzero = (en_half_q != '0);

  clns_front u_front (
    .req_i       (req_i),
    .job_valid_o (fe_valid),
    .job_o       (fe_job)
  );

  clns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start_i && fe_valid),
    .job_i   (fe_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (q_job)
  );

  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (q_pop),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

  assign busy_o = q_full;

  `ASSERT_NEXT(a_burst_contig, clk_i, rst_ni, valid_o && !res_o.last, valid_o)
  `ASSERT_IMPL(a_wait_only_zero, clk_i, rst_ni, valid_o && !res_o.strobe_res,
               !res_o.rs && res_o.nibble == 4'h0 && res_o.wait_after == WAIT_POWER_UP)
  `ASSERT_NEVER(a_half_period_zero, clk_i, rst_ni,
                !half_nonzero && !$past(cfg_we_i) && $past(!rst_ni))

endmodule

// File: tb/sv/tb_char_lcd_nibble_sequencer.sv
// Self-checking testbench for char_lcd_nibble_sequencer: random and directed LCD requests,
// each expanded into the expected nibble transfers and compared beat by beat on res_o.
// Depends on clns_pkg and the RTL of the sequencer.
module tb_char_lcd_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import clns_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  class lcd_xfer_scoreboard;
    res_t        pending_xfers[$];
    res_t        batch[$];
    logic [19:0] half_period = 20'd8000;
    int unsigned errors = 0;

    function void push_xfer(logic rs, logic [3:0] nib, logic stb, logic [18:0] w);
      res_t x;
      x.rs         = rs;
      x.nibble     = nib;
      x.strobe_res = stb;
      x.wait_after = w;
      x.last       = 1'b0;
      batch.push_back(x);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic [18:0] w);
      push_xfer(rs, b[7:4], 1'b1, '0);
      push_xfer(rs, b[3:0], 1'b1, w);
    endfunction

    // expand one accepted request into its transfers
    function void note_request(req_t r);
      batch.delete();
      case (r.cmd)
        CMD_INIT: begin
          push_xfer(1'b0, 4'h0, 1'b0, WAIT_POWER_UP);
          push_xfer(1'b0, 4'h3, 1'b1, WAIT_FIRST_NIB);
          push_xfer(1'b0, 4'h3, 1'b1, WAIT_NIB);
          push_xfer(1'b0, 4'h3, 1'b1, WAIT_NIB);
          push_xfer(1'b0, 4'h2, 1'b1, WAIT_NIB);
          push_byte(1'b0, LCD_FUNC_SET, '0);
          push_byte(1'b0, LCD_DISP_ON, '0);
          push_byte(1'b0, LCD_CLR_DISP, WAIT_CLEAR);
        end
        CMD_CMD:    push_byte(1'b0, r.value, '0);
        CMD_DATA:   push_byte(1'b1, r.value, '0);
        CMD_CLEAR:  push_byte(1'b0, LCD_CLR_DISP, WAIT_CLEAR);
        CMD_CURSOR: push_byte(1'b0, (r.row ? LCD_DDRAM_L1 : LCD_DDRAM_L0) + {2'b00, r.col}, '0);
        CMD_GLYPH: begin
          if (r.glyph_row == 3'd0)
            push_byte(1'b0, LCD_CGRAM | {2'b00, r.location, 3'b000}, '0);
          push_byte(1'b1, r.value, '0);
          if (r.glyph_row == 3'd7)
            push_byte(1'b0, LCD_DDRAM_L0, '0);
        end
        default: ;
      endcase
      if (batch.size() > 0)
        batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
        pending_xfers.push_back(batch[i]);
    endfunction

    function void cmp_field(string name, logic [18:0] exp_v, logic [18:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_xfer(res_t act);
      res_t exp_x;
      if (pending_xfers.size() == 0) begin
        errors++;
        $display("%0t: transfer expected none actual %0h", $time, act);
        return;
      end
      exp_x = pending_xfers.pop_front();
      cmp_field("rs", 19'(exp_x.rs), 19'(act.rs));
      cmp_field("nibble", 19'(exp_x.nibble), 19'(act.nibble));
      cmp_field("strobe_res", 19'(exp_x.strobe_res), 19'(act.strobe_res));
      cmp_field("wait_after", exp_x.wait_after, act.wait_after);
      cmp_field("last", 19'(exp_x.last), 19'(act.last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  req_t        req_i;
  logic        cfg_we_i;
  logic [19:0] cfg_wdata_i;
  logic        valid_o;
  res_t        res_o;

  lcd_xfer_scoreboard sb = new();
  int unsigned burst_left = 0;

  char_lcd_nibble_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_request(req_i);
    if (rst_ni && valid_o)
      sb.check_xfer(res_o);
  end

  function automatic req_t rand_req(logic [2:0] cmd);
    req_t r;
    r = req_t'(24'($urandom));
    r.cmd = cmd;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      if (gap != 0) begin
        start_i <= 1'b0;
        req_i <= rand_req(3'($urandom));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_xfers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [19:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.half_period = v;
  endtask

  task automatic glyph_run();
    req_t r;
    logic [2:0] loc;
    loc = 3'($urandom);
    for (int g = 0; g < 8; g++) begin
      r = rand_req(CMD_GLYPH);
      r.location = loc;
      r.glyph_row = 3'(g);
      send_req(r);
    end
  endtask

  task automatic run_directed();
    req_t r;
    send_req(rand_req(CMD_INIT));
    r = rand_req(CMD_CMD);    r.value = 8'h00; send_req(r);
    r = rand_req(CMD_CMD);    r.value = 8'hFF; send_req(r);
    r = rand_req(CMD_DATA);   r.value = 8'h00; send_req(r);
    r = rand_req(CMD_DATA);   r.value = 8'hFF; send_req(r);
    r = rand_req(CMD_DATA);   r.value = 8'hA5; send_req(r);
    send_req(rand_req(CMD_CLEAR));
    for (int i = 0; i < 4; i++) begin
      r = rand_req(CMD_CURSOR);
      r.row = i[0];
      r.col = i[1] ? 6'd63 : 6'd0;
      send_req(r);
    end
    r = rand_req(CMD_GLYPH); r.glyph_row = 3'd0; r.location = 3'd0; r.value = 8'h00; send_req(r);
    r = rand_req(CMD_GLYPH); r.glyph_row = 3'd0; r.location = 3'd7; r.value = 8'hFF; send_req(r);
    r = rand_req(CMD_GLYPH); r.glyph_row = 3'd3; send_req(r);
    r = rand_req(CMD_GLYPH); r.glyph_row = 3'd7; r.value = 8'hFF; send_req(r);
    send_req(rand_req(3'd6));
    send_req(rand_req(3'd7));
    send_req(rand_req(CMD_INIT));
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_req(rand_req(3'($urandom_range(6, 7))));
      end else if (pick < 4) begin
        glyph_run();
        done += 8;
      end else if (pick == 4) begin
        send_req(rand_req(CMD_INIT));
        done++;
      end else begin
        send_req(rand_req(3'($urandom_range(1, 5))));
        done++;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_half_period(20'd1048575);
    run_directed();
    drain();
    write_half_period(20'd1);
    run_random(ITEMS_PER_PHASE);
    drain();
    write_half_period(20'($urandom_range(1, 1048575)));
    run_random(ITEMS_PER_PHASE);
    drain();
    write_half_period(20'd8000);
    run_random(ITEMS_PER_PHASE);
    drain();
    write_half_period(20'd1048575);
    run_random(ITEMS_PER_PHASE);
    drain();
    if (sb.errors == 0 && sb.pending_xfers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/clns_pkg.sv
hdl/clns_front.sv
hdl/clns_queue.sv
hdl/clns_back.sv
hdl/char_lcd_nibble_sequencer.sv
tb/sv/tb_char_lcd_nibble_sequencer.sv
